// ===== rtl/pcem_pkg.sv =====
// Shared types, constants and helpers of the pendulum chain energy monitor.
// No dependencies; used by every module of the block.
package pcem_pkg;

  // Angle constants, Q3.28
  localparam logic [31:0] TWO_PI_Q  = 32'd1686629713;
  localparam logic [31:0] PI_Q      = 32'd843314857;
  localparam logic [31:0] HALF_PI_Q = 32'd421657428;
  localparam logic [28:0] ANG_ONE   = 29'd268435456;

  // Largest energy magnitude, Q24.24
  localparam logic [46:0] MAX47 = {47{1'b1}};

  // Chain position saturates here
  localparam logic [11:0] POS_MAX = 12'd4095;

  // Horner divisors of the cosine series and their reciprocals, 2^31 / d
  localparam int HORNER_STEPS = 6;
  localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [30:0] HORNER_RECIP [HORNER_STEPS] = '{
    31'(64'd2147483648 / 64'd132), 31'(64'd2147483648 / 64'd90),
    31'(64'd2147483648 / 64'd56),  31'(64'd2147483648 / 64'd30),
    31'(64'd2147483648 / 64'd12),  31'(64'd2147483648 / 64'd2)};

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MASS, REG_ARM_LENGTH, REG_GRAVITY, REG_COUPLING, REG_INV_DT2, REG_COUNT
  } reg_index_t;

  typedef struct packed {
    logic [30:0]        mass;
    logic [30:0]        arm_length;
    logic signed [31:0] gravity_coeff;
    logic signed [31:0] coupling_coeff;
    logic [30:0]        inv_dt_squared;
  } coef_t;

  // Classified pendulum, front to back
  typedef struct packed {
    logic [31:0] kin_mag;    // |now - before|
    logic [32:0] coup_mag;   // |now - next + offset|
    logic [31:0] angle_mag;  // |now|
    logic        kin_left;
    logic        coup_left;
    logic        last;
  } pend_item_t;

  // One frame result; last field in the lowest bits
  typedef struct packed {
    logic [46:0]        peak_side;
    logic [46:0]        peak_total;
    logic signed [47:0] total_both;
    logic signed [47:0] total_right;
    logic signed [47:0] total_left;
    logic signed [47:0] gravity_right;
    logic signed [47:0] gravity_left;
    logic signed [47:0] coupling_right;
    logic signed [47:0] coupling_left;
    logic signed [47:0] kinetic_right;
    logic signed [47:0] kinetic_left;
  } result_t;

  // Coefficient picked by each step of the multiply chains
  typedef enum logic [2:0] {CF_MASS, CF_ARM, CF_GRAV, CF_COUP, CF_IDT} coef_sel_t;

  localparam logic [3:0] STEP_KIN_END  = 4'd3;
  localparam logic [3:0] STEP_GRAV_END = 4'd7;
  localparam logic [3:0] STEP_COUP_END = 4'd12;

  function automatic coef_sel_t coef_of(logic [3:0] step);
    coef_sel_t c;
    case (step)
      4'd0:    c = CF_MASS;
      4'd1:    c = CF_ARM;
      4'd2:    c = CF_ARM;
      4'd3:    c = CF_IDT;
      4'd4:    c = CF_ARM;
      4'd5:    c = CF_MASS;
      4'd6:    c = CF_GRAV;
      4'd7:    c = CF_IDT;
      4'd8:    c = CF_ARM;
      4'd9:    c = CF_ARM;
      4'd10:   c = CF_MASS;
      4'd11:   c = CF_COUP;
      default: c = CF_IDT;
    endcase
    return c;
  endfunction

  typedef enum logic [4:0] {
    B_IDLE, B_SQK, B_SQ_W, B_MLO, B_MHI, B_MSUM, B_ACC,
    B_FOLD1, B_FOLD2, B_X2, B_X2_W, B_H_MUL, B_H_REC, B_H_COR, B_GINIT,
    B_SQC, B_TOT1, B_TOT2, B_TOT3, B_WR, B_SCAN, B_DRAIN, B_OUT
  } back_state_t;

  // Saturating add on 48-bit signed energies
  function automatic logic signed [47:0] sadd(logic signed [47:0] a,
                                              logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'd0} : {1'b0, MAX47};
    end
    return s[47:0];
  endfunction

endpackage

// ===== rtl/pcem_front.sv =====
// Front part: accepts pendulum items, forms angle differences and places
// each pendulum on the left or right half. Depends on pcem_pkg.
module pcem_front import pcem_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [12:0]  pendulum_count,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // angle_now, angle_before, neighbour_angle, phase_offset
  input  logic         s_tlast,   // frame_last
  input  logic         queue_full,
  output logic         push,
  output pend_item_t   item
);

  logic [11:0]        chain_position;
  logic signed [31:0] now, prev, nbr, offset;
  logic signed [32:0] now_x, kin_diff;
  logic signed [33:0] coup_diff;
  logic [12:0]        half, pos_x;

  assign now    = s_tdata[31:0];
  assign prev   = s_tdata[63:32];
  assign nbr    = s_tdata[95:64];
  assign offset = s_tdata[127:96];

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  // Differences and magnitudes
  always_comb begin
    now_x     = {now[31], now};
    kin_diff  = now_x - {prev[31], prev};
    coup_diff = {now[31], now_x} - {{2{nbr[31]}}, nbr} + {{2{offset[31]}}, offset};
    half      = pendulum_count >> 1;
    pos_x     = {1'b0, chain_position};
    item.kin_mag   = kin_diff[32] ? 32'(-kin_diff) : kin_diff[31:0];
    item.coup_mag  = coup_diff[33] ? 33'(-coup_diff) : coup_diff[32:0];
    item.angle_mag = now_x[32] ? 32'(-now_x) : now_x[31:0];
    item.kin_left  = pos_x < half;
    item.coup_left = (pos_x + 13'd1) < half;
    item.last      = s_tlast;
  end

  // Advance chain position, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_position <= '0;
    end else if (push) begin
      if (s_tlast) begin
        chain_position <= '0;
      end else if (chain_position != POS_MAX) begin
        chain_position <= chain_position + 12'd1;
      end
    end
  end

endmodule

// ===== rtl/pcem_queue.sv =====
// Two-entry queue of classified pendulums between front and back.
// Depends on pcem_pkg.
module pcem_queue import pcem_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pend_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output pend_item_t head
);

  pend_item_t  slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/pcem_back.sv =====
// Back part: energy arithmetic on one shared multiplier, accumulation,
// history rings and the peak scan; holds the result register. Uses pcem_pkg.
module pcem_back import pcem_pkg::*; #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  coef_t      coef,
  input  logic       item_valid,
  input  pend_item_t item,
  output logic       item_pop,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(HISTORY_DEPTH);

  typedef struct packed {
    logic signed [47:0] left;
    logic signed [47:0] right;
    logic signed [47:0] both;
  } hist_t;

  back_state_t state, state_next;

  logic [3:0]  step;
  logic [2:0]  hidx;
  logic [46:0] val;
  logic        neg;
  logic [63:0] lo;
  logic [31:0] u;
  logic [28:0] x, t;
  logic        flip;
  logic [29:0] x2, p;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic signed [47:0] acc [6];
  logic signed [47:0] tl, tr, tb;
  logic [SW-1:0] slot, scan_addr;
  logic [FW-1:0] fill;
  hist_t hist_mem [HISTORY_DEPTH];
  hist_t rdata;
  logic  rd_valid;
  logic signed [47:0] peak_t, peak_s, side_max;
  logic  load_out;

  // Coefficient magnitude and sign of the current chain step
  logic [31:0] cmag;
  logic        cneg;
  always_comb begin
    cmag = '0;
    cneg = 1'b0;
    case (coef_of(step))
      CF_MASS: cmag = {1'b0, coef.mass};
      CF_ARM:  cmag = {1'b0, coef.arm_length};
      CF_GRAV: begin
        cmag = coef.gravity_coeff[31] ? 32'(-coef.gravity_coeff) : coef.gravity_coeff;
        cneg = coef.gravity_coeff[31];
      end
      CF_COUP: begin
        cmag = coef.coupling_coeff[31] ? 32'(-coef.coupling_coeff)
                                       : coef.coupling_coeff;
        cneg = coef.coupling_coeff[31];
      end
      CF_IDT:  cmag = {1'b0, coef.inv_dt_squared};
      default: cmag = '0;
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_SQK:   begin mul_a = {1'b0, item.kin_mag}; mul_b = {1'b0, item.kin_mag}; end
      B_SQC:   begin mul_a = item.coup_mag; mul_b = item.coup_mag; end
      B_MLO:   begin mul_a = {1'b0, val[31:0]}; mul_b = {1'b0, cmag}; end
      B_MHI:   begin mul_a = {18'd0, val[46:32]}; mul_b = {1'b0, cmag}; end
      B_X2:    begin mul_a = {4'd0, x}; mul_b = {4'd0, x}; end
      B_H_MUL: begin mul_a = {3'd0, x2}; mul_b = {4'd0, t}; end
      B_H_REC: begin mul_a = {3'd0, prod[57:28]}; mul_b = {2'd0, HORNER_RECIP[hidx]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Cosine folding, Horner step and chain arithmetic
  logic [31:0] u1, u2;
  logic [29:0] q0, qf, h;
  logic [37:0] qd, rem;
  logic [66:0] sq_round;
  logic [63:0] qsum;
  logic [47:0] half_mag, contrib;
  logic [2:0]  acc_idx;
  logic        kin_end, grav_end, coup_end;
  always_comb begin
    u1 = (item.angle_mag >= TWO_PI_Q) ? item.angle_mag - TWO_PI_Q : item.angle_mag;
    u2 = (u1 > PI_Q) ? TWO_PI_Q - u1 : u1;
    q0 = prod[60:31];
    qd = q0 * HORNER_DIV[hidx];
    rem = {8'd0, p} - qd;
    qf = (rem >= 38'(HORNER_DIV[hidx])) ? q0 + 30'd1 : q0;
    h = flip ? {1'b0, ANG_ONE} + {1'b0, t} : {1'b0, ANG_ONE} - {1'b0, t};
    sq_round = {1'b0, prod} + 67'd2147483648;
    qsum = {prod[47:0], 16'd0} + {16'd0, lo[63:16]};
    kin_end  = step == STEP_KIN_END;
    grav_end = step == STEP_GRAV_END;
    coup_end = step == STEP_COUP_END;
    half_mag = ({1'b0, val} + 48'd1) >> 1;
    if (grav_end) begin
      contrib = neg ? {1'b0, val} : -{1'b0, val};
    end else if (kin_end) begin
      contrib = neg ? -half_mag : half_mag;
    end else begin
      contrib = neg ? half_mag : -half_mag;
    end
    if (kin_end) acc_idx = item.kin_left ? 3'd0 : 3'd1;
    else if (grav_end) acc_idx = item.kin_left ? 3'd4 : 3'd5;
    else acc_idx = item.coup_left ? 3'd2 : 3'd3;
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE:  if (item_valid) state_next = B_SQK;
      B_SQK:   state_next = B_SQ_W;
      B_SQC:   state_next = B_SQ_W;
      B_SQ_W:  state_next = B_MLO;
      B_MLO:   state_next = B_MHI;
      B_MHI:   state_next = B_MSUM;
      B_MSUM:  state_next = (kin_end || grav_end || coup_end) ? B_ACC : B_MLO;
      B_ACC: begin
        if (kin_end) begin
          state_next = B_FOLD1;
        end else if (grav_end) begin
          state_next = B_SQC;
        end else if (item.last) begin
          state_next = B_TOT1;
        end else begin
          item_pop   = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_FOLD1: state_next = B_FOLD2;
      B_FOLD2: state_next = B_X2;
      B_X2:    state_next = B_X2_W;
      B_X2_W:  state_next = B_H_MUL;
      B_H_MUL: state_next = B_H_REC;
      B_H_REC: state_next = B_H_COR;
      B_H_COR: state_next = (hidx == 3'(HORNER_STEPS - 1)) ? B_GINIT : B_H_MUL;
      B_GINIT: state_next = B_MLO;
      B_TOT1:  state_next = B_TOT2;
      B_TOT2:  state_next = B_TOT3;
      B_TOT3:  state_next = B_WR;
      B_WR:    state_next = B_SCAN;
      B_SCAN:  if (scan_addr == LAST_SLOT) state_next = B_DRAIN;
      B_DRAIN: state_next = B_OUT;
      B_OUT: begin
        if (!res_valid || res_ready) begin
          load_out   = 1'b1;
          item_pop   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE:  step <= '0;
      B_SQ_W: begin
        val <= 47'(sq_round >> 32);
        neg <= 1'b0;
      end
      B_MHI:   lo <= prod[63:0] + 64'h8000;
      B_MSUM: begin
        val <= (qsum > {17'd0, MAX47}) ? MAX47 : qsum[46:0];
        neg <= (qsum != 64'd0) && (neg ^ cneg);
        if (!(kin_end || grav_end || coup_end)) step <= step + 4'd1;
      end
      B_ACC:   step <= step + 4'd1;
      B_FOLD1: u <= u2;
      B_FOLD2: begin
        flip <= u > HALF_PI_Q;
        x    <= (u > HALF_PI_Q) ? 29'(PI_Q - u) : u[28:0];
      end
      B_X2_W: begin
        x2   <= prod[57:28];
        t    <= ANG_ONE;
        hidx <= '0;
      end
      B_H_REC: p <= prod[57:28];
      B_H_COR: begin
        t    <= (qf >= {1'b0, ANG_ONE}) ? 29'd0 : 29'({1'b0, ANG_ONE} - qf);
        hidx <= hidx + 3'd1;
      end
      B_GINIT: begin
        val <= {21'd0, 26'((h + 30'd8) >> 4)};
        neg <= 1'b0;
      end
      B_TOT1:  tl <= sadd(sadd(acc[0], acc[2]), acc[4]);
      B_TOT2:  tr <= sadd(sadd(acc[1], acc[3]), acc[5]);
      B_TOT3:  tb <= sadd(tl, tr);
      default: ;
    endcase
  end

  // Accumulate energies, clear after the frame result
  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      for (int i = 0; i < 6; i++) acc[i] <= '0;
    end else if (state == B_ACC) begin
      acc[acc_idx] <= sadd(acc[acc_idx], contrib);
    end
  end

  // Advance history slot and fill count at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (state == B_TOT3) begin
      slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      if (fill != FULL_FILL) fill <= fill + 1'b1;
    end
  end

  // History rings; entries never written read as zero through rd_valid
  always_ff @(posedge clk) begin
    if (state == B_WR) begin
      hist_mem[slot] <= '{left: tl, right: tr, both: tb};
    end
    rdata <= hist_mem[scan_addr];
  end

  // Walk the rings, tracking window peaks with a floor of zero
  always_comb begin
    side_max = peak_s;
    if (rdata.left > side_max)  side_max = rdata.left;
    if (rdata.right > side_max) side_max = rdata.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == B_SCAN) &&
                  ((fill == FULL_FILL) || (scan_addr != '0 && FW'(scan_addr) <= fill));
    end
    if (state == B_WR) scan_addr <= '0;
    else if (state == B_SCAN && scan_addr != LAST_SLOT) scan_addr <= scan_addr + 1'b1;
    if (state == B_TOT3) begin
      peak_t <= '0;
      peak_s <= '0;
    end else if (rd_valid) begin
      if (rdata.both > peak_t) peak_t <= rdata.both;
      peak_s <= side_max;
    end
  end

  // Result register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (load_out) begin
      res.kinetic_left   <= acc[0];
      res.kinetic_right  <= acc[1];
      res.coupling_left  <= acc[2];
      res.coupling_right <= acc[3];
      res.gravity_left   <= acc[4];
      res.gravity_right  <= acc[5];
      res.total_left     <= tl;
      res.total_right    <= tr;
      res.total_both     <= tb;
      res.peak_total     <= peak_t[46:0];
      res.peak_side      <= peak_s[46:0];
    end
  end

endmodule

// ===== rtl/pendulum_chain_energy_monitor.sv =====
// Pendulum chain energy monitor top level: configuration registers, front,
// queue and back. Depends on pcem_pkg, pcem_front, pcem_queue, pcem_back.
//
// Usage: pendulums of a frame arrive in chain order on the s_ channel, one
// item each; s_tlast marks the last pendulum. Each frame yields one result
// item on the m_ channel with the six half energies, the three totals and
// the window peaks of the history rings. Registers are to be written on the
// cfg_ channel only while the block is idle; the block does not enforce it.
// Arithmetic: the kinetic, gravity and coupling multiply chains plus the
// six-step cosine series all share one 33x33 multiplier in the back part,
// which finishes one pendulum before it takes the next. The last pendulum
// of a frame adds the ring write and the peak walk over the history
// memory, one entry per cycle.
// Reset clears registers to their defaults, the chain position, the energy
// accumulators and the history fill count; no clearing pass is needed.
// When the receiver stalls, the result register holds; the two-entry queue
// keeps taking pendulums until it fills.
module pendulum_chain_energy_monitor import pcem_pkg::*; #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // angle_now, angle_before, neighbour_angle, phase_offset
  input  logic         s_tlast,   // frame_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [527:0] m_tdata,   // kinetic_left, kinetic_right, coupling_left,
                                  // coupling_right, gravity_left, gravity_right,
                                  // total_left, total_right, total_both,
                                  // peak_total, peak_side, zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  coef_t       coef;
  logic [12:0] pendulum_count;
  logic        push, queue_full, head_valid, pop;
  pend_item_t  push_item, head;
  result_t     res;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.mass           <= 31'd65536;
      coef.arm_length     <= 31'd65536;
      coef.gravity_coeff  <= '0;
      coef.coupling_coeff <= '0;
      coef.inv_dt_squared <= 31'd65536;
      pendulum_count      <= 13'd2;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_MASS:       coef.mass           <= cfg_data[30:0];
        REG_ARM_LENGTH: coef.arm_length     <= cfg_data[30:0];
        REG_GRAVITY:    coef.gravity_coeff  <= cfg_data;
        REG_COUPLING:   coef.coupling_coeff <= cfg_data;
        REG_INV_DT2:    coef.inv_dt_squared <= cfg_data[30:0];
        REG_COUNT:      pendulum_count      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  pcem_front u_front (
    .clk            (clk),
    .rst            (rst),
    .pendulum_count (pendulum_count),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .queue_full     (queue_full),
    .push           (push),
    .item           (push_item)
  );

  pcem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pcem_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .item_valid (head_valid),
    .item       (head),
    .item_pop   (pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {2'b00, res};

endmodule
